// ===== sv/phtst_pkg.sv =====
// shared types and constants of the polyline hit test
package phtst_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int COORD_WIDTH_CAP = 30;
  localparam int TOL_WIDTH       = 25;
  localparam int T_FRAC          = 16;
  localparam int CFG_IDX_WIDTH   = 1;

  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CLOSED_MODE = 1'b0;
  localparam cfg_idx_t REG_TOLERANCE   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_GO,
    S_MUL_WAIT,
    S_TSEL,
    S_DIV_WAIT,
    S_RXY,
    S_KEEP,
    S_SQRT_WAIT,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_DXDX,
    MUL_DYDY,
    MUL_WXDX,
    MUL_WYDY,
    MUL_TDX,
    MUL_TDY,
    MUL_RXRX,
    MUL_RYRY
  } mop_t;

endpackage

// ===== sv/phtst_ifs.sv =====
// vertex and result channel interfaces
interface phtst_vertex_if #(
  parameter int COORD_WIDTH = phtst_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic                          last_vertex;

  modport source(output valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
                 input ready);
  modport sink(input valid, vertex_x, vertex_y, query_x, query_y, last_vertex,
               output ready);
endinterface

interface phtst_result_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [phtst_pkg::TOL_WIDTH-1:0]    distance;

  modport source(output valid, hit, distance, input ready);
  modport sink(input valid, hit, distance, output ready);
endinterface

// ===== sv/phtst_mul.sv =====
// bit-serial signed multiplier, one multiplier bit per cycle
module phtst_mul #(
  parameter int MW = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic                busy,
  output logic                done,
  output logic signed [2*MW:0] prod
);
  localparam int CNT_W = $clog2(MW + 1);

  logic [2*MW-1:0] acc;
  logic [2*MW-1:0] a_sh;
  logic [MW-1:0]   b_sh;
  logic            neg;
  logic [CNT_W-1:0] cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= (2*MW)'(a[MW-1] ? MW'(-a) : MW'(a));
      b_sh <= b[MW-1] ? MW'(-b) : MW'(b);
      neg  <= a[MW-1] ^ b[MW-1];
    end else if (busy) begin
      if (b_sh[0]) acc <= acc + a_sh;
      a_sh <= {a_sh[2*MW-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[MW-1:1]};
    end
  end

  // apply sign
  always_comb begin
    prod = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  end
endmodule

// ===== sv/phtst_div.sv =====
// restoring divider for the Q0.16 projection parameter, one quotient bit per cycle
module phtst_div #(
  parameter int DW = 56
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 num,
  input  logic [DW-1:0]                 den,
  output logic                          done,
  output logic [phtst_pkg::T_FRAC-1:0]  quo
);
  import phtst_pkg::*;

  localparam int CNT_W = $clog2(T_FRAC + 1);

  logic [DW-1:0]    r;
  logic [DW-1:0]    d;
  logic [DW-1:0]    r2;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(T_FRAC);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shifted remainder
  assign r2 = {r[DW-2:0], 1'b0};

  // one restoring step
  always_ff @(posedge clk) begin
    if (start) begin
      r   <= num;
      d   <= den;
      quo <= '0;
    end else if (busy) begin
      if (r2 >= d) begin
        r   <= r2 - d;
        quo <= {quo[T_FRAC-2:0], 1'b1};
      end else begin
        r   <= r2;
        quo <= {quo[T_FRAC-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/phtst_sqrt.sv =====
// digit-by-digit floor square root, one root bit per cycle
module phtst_sqrt #(
  parameter int DW = 56
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DW-1:0]     value,
  output logic              done,
  output logic [DW/2-1:0]   root
);
  localparam int R     = DW / 2;
  localparam int CNT_W = $clog2(R + 1);

  logic [DW-1:0]    v;
  logic [DW-1:0]    res;
  logic [DW-1:0]    bitm;
  logic [DW-1:0]    trial;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(R);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign trial = res + bitm;

  // one root digit
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= value;
      res  <= '0;
      bitm <= DW'(1) << (DW - 2);
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign root = res[R-1:0];
endmodule

// ===== sv/polyline_hit_test.sv =====
// polyline hit test top level: sequencer, segment datapath and result register
//
// Vertices arrive on the vertices channel, one transfer per vertex; the query
// point is taken from the first vertex of each polyline and last_vertex closes
// it. Each last vertex gives one transfer on the results channel: hit and the
// floor distance (Q25.0), distance zero on a miss or with fewer than two
// vertices. closed_mode and tolerance are set over the wr_en/wr_index/wr_data
// port; the user must write them only while the block is idle, which the
// block itself does not enforce. Every segment runs up to eight products
// through one bit-serial multiplier of MW = max(coord+3, 18) bits, with coord
// capped at 30, and through the serial divider for t when the projection
// falls inside the segment. In closed mode the last vertex also runs the
// closing segment back to the first vertex, and the last vertex of a polyline
// with two or more vertices then passes through the serial square root.
// Reset (synchronous, active high) resets the control state and starts a new
// polyline. A result waits in its output register while the receiver stalls;
// the next vertex is taken meanwhile and only a following result waits.
module polyline_hit_test #(
  parameter int COORD_WIDTH = phtst_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  phtst_vertex_if.sink                          vertices,
  phtst_result_if.source                        results,
  input  logic                                  wr_en,
  input  logic [phtst_pkg::CFG_IDX_WIDTH-1:0]   wr_index,
  input  logic [phtst_pkg::TOL_WIDTH-1:0]       wr_data
);
  import phtst_pkg::*;

  localparam int EW = (COORD_WIDTH > COORD_WIDTH_CAP) ? COORD_WIDTH_CAP : COORD_WIDTH;
  localparam int V  = EW + 1;
  localparam int MW = (EW + 3 > T_FRAC + 2) ? EW + 3 : T_FRAC + 2;
  localparam int DW = 2 * MW + 2;
  localparam int R  = DW / 2;
  localparam int CW = (R > TOL_WIDTH) ? R : TOL_WIDTH;

  state_t state, state_next;
  mop_t   mop;

  // configuration
  logic                 closed_mode;
  logic [TOL_WIDTH-1:0] tolerance;

  // polyline state
  logic signed [EW-1:0] prev_x, prev_y, first_x, first_y, qx, qy;
  logic signed [EW-1:0] sx, sy, ex, ey;
  logic [1:0]           vertex_count;
  logic                 last_flag, closing;
  logic [DW-1:0]        best_dist_sq;

  // segment datapath
  logic signed [V-1:0]    dx, dy, wx, wy;
  logic [DW-1:0]          len2, cand_dsq;
  logic signed [DW-1:0]   dot;
  logic [T_FRAC:0]        t;
  logic signed [EW+1:0]   px, py;
  logic signed [EW+2:0]   rx, ry;

  // result
  logic                 res_hit;
  logic [TOL_WIDTH-1:0] res_dist;
  logic                 o_valid, o_hit;
  logic [TOL_WIDTH-1:0] o_dist;

  // unit handshakes
  logic                  mul_start, mul_busy, mul_done;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [2*MW:0]  mul_prod;
  logic signed [DW-1:0]  pext, pround, pshift;
  logic                  div_start, div_done;
  logic [T_FRAC-1:0]     div_q;
  logic                  sqrt_start, sqrt_done;
  logic [R-1:0]          sqrt_root;
  logic [DW-1:0]         best_min;
  logic [CW-1:0]         root_ext;
  logic                  in_fire, out_free;
  logic                  len_zero, dot_le0, dot_ge_len;

  assign in_fire  = vertices.valid && vertices.ready;
  assign out_free = !o_valid || results.ready;
  assign len_zero   = (len2 == '0);
  assign dot_le0    = dot[DW-1] || (dot == '0);
  assign dot_ge_len = $unsigned(dot) >= len2;
  assign best_min   = (cand_dsq < best_dist_sq) ? cand_dsq : best_dist_sq;
  assign root_ext   = CW'(sqrt_root);

  // product extension and rounded projection offset
  assign pext   = DW'(mul_prod);
  assign pround = pext + DW'(32768);
  assign pshift = pround >>> T_FRAC;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_mode <= 1'b0;
      tolerance   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CLOSED_MODE: closed_mode <= wr_data[0];
        REG_TOLERANCE:   tolerance   <= wr_data;
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    unique case (mop)
      MUL_DXDX: begin mul_a = MW'(dx); mul_b = MW'(dx); end
      MUL_DYDY: begin mul_a = MW'(dy); mul_b = MW'(dy); end
      MUL_WXDX: begin mul_a = MW'(wx); mul_b = MW'(dx); end
      MUL_WYDY: begin mul_a = MW'(wy); mul_b = MW'(dy); end
      MUL_TDX:  begin mul_a = MW'(t);  mul_b = MW'(dx); end
      MUL_TDY:  begin mul_a = MW'(t);  mul_b = MW'(dy); end
      MUL_RXRX: begin mul_a = MW'(rx); mul_b = MW'(rx); end
      MUL_RYRY: begin mul_a = MW'(ry); mul_b = MW'(ry); end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (vertex_count != 2'd0) state_next = S_PREP;
          else if (vertices.last_vertex) state_next = S_EMIT;
        end
      end
      S_PREP:   state_next = S_MUL_GO;
      S_MUL_GO: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mop)
            MUL_WYDY: state_next = S_TSEL;
            MUL_TDY:  state_next = S_RXY;
            MUL_RYRY: state_next = S_KEEP;
            default:  state_next = S_MUL_GO;
          endcase
        end
      end
      S_TSEL: begin
        priority if (len_zero) state_next = S_RXY;
        else if (dot_le0 || dot_ge_len) state_next = S_MUL_GO;
        else state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: if (div_done) state_next = S_MUL_GO;
      S_RXY:      state_next = S_MUL_GO;
      S_KEEP: begin
        priority if (closing) state_next = S_PREP;
        else if (last_flag) state_next = S_SQRT_WAIT;
        else state_next = S_IDLE;
      end
      S_SQRT_WAIT: if (sqrt_done) state_next = S_EMIT;
      S_EMIT:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    vertices.ready = (state == S_IDLE);
    mul_start      = (state == S_MUL_GO);
    div_start      = (state == S_TSEL) && !len_zero && !dot_le0 && !dot_ge_len;
    sqrt_start     = (state == S_KEEP) && !closing && last_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // polyline control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 2'd0;
      best_dist_sq <= '1;
      closing      <= 1'b0;
      last_flag    <= 1'b0;
      mop          <= MUL_DXDX;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            last_flag <= vertices.last_vertex;
            if (vertex_count == 2'd0) begin
              best_dist_sq <= '1;
              vertex_count <= vertices.last_vertex ? 2'd0 : 2'd1;
              closing      <= 1'b0;
            end else begin
              vertex_count <= vertices.last_vertex ? 2'd0 : 2'd2;
              closing      <= vertices.last_vertex && closed_mode;
            end
          end
        end
        S_PREP: mop <= MUL_DXDX;
        S_MUL_WAIT: begin
          if (mul_done && mop != MUL_WYDY && mop != MUL_TDY && mop != MUL_RYRY)
            mop <= mop_t'(mop + 3'd1);
        end
        S_TSEL: if (!len_zero) mop <= MUL_TDX;
        S_RXY:  mop <= MUL_RXRX;
        S_KEEP: begin
          best_dist_sq <= best_min;
          if (closing) closing <= 1'b0;
          else if (last_flag) best_dist_sq <= '1;
        end
        default: ;
      endcase
    end
  end

  // segment datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          prev_x <= vertices.vertex_x[EW-1:0];
          prev_y <= vertices.vertex_y[EW-1:0];
          sx     <= prev_x;
          sy     <= prev_y;
          ex     <= vertices.vertex_x[EW-1:0];
          ey     <= vertices.vertex_y[EW-1:0];
          if (vertex_count == 2'd0) begin
            qx      <= vertices.query_x[EW-1:0];
            qy      <= vertices.query_y[EW-1:0];
            first_x <= vertices.vertex_x[EW-1:0];
            first_y <= vertices.vertex_y[EW-1:0];
            res_hit  <= 1'b0;
            res_dist <= '0;
          end
        end
      end
      S_PREP: begin
        dx <= V'(ex) - V'(sx);
        dy <= V'(ey) - V'(sy);
        wx <= V'(qx) - V'(sx);
        wy <= V'(qy) - V'(sy);
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          unique case (mop)
            MUL_DXDX: len2     <= pext;
            MUL_DYDY: len2     <= len2 + pext;
            MUL_WXDX: dot      <= pext;
            MUL_WYDY: dot      <= dot + pext;
            MUL_TDX:  px       <= (EW+2)'(sx) + pshift[EW+1:0];
            MUL_TDY:  py       <= (EW+2)'(sy) + pshift[EW+1:0];
            MUL_RXRX: cand_dsq <= pext;
            MUL_RYRY: cand_dsq <= cand_dsq + pext;
          endcase
        end
      end
      S_TSEL: begin
        if (len_zero) begin
          px <= (EW+2)'(sx);
          py <= (EW+2)'(sy);
        end else if (dot_le0) begin
          t <= '0;
        end else if (dot_ge_len) begin
          t <= (T_FRAC+1)'(1) << T_FRAC;
        end
      end
      S_DIV_WAIT: if (div_done) t <= {1'b0, div_q};
      S_RXY: begin
        rx <= (EW+3)'(qx) - (EW+3)'(px);
        ry <= (EW+3)'(qy) - (EW+3)'(py);
      end
      S_KEEP: begin
        if (closing) begin
          sx <= ex;
          sy <= ey;
          ex <= first_x;
          ey <= first_y;
        end
      end
      S_SQRT_WAIT: begin
        if (sqrt_done) begin
          res_hit  <= (root_ext <= CW'(tolerance));
          res_dist <= (root_ext <= CW'(tolerance)) ? root_ext[TOL_WIDTH-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      o_hit  <= res_hit;
      o_dist <= res_dist;
    end
  end

  assign results.valid    = o_valid;
  assign results.hit      = o_hit;
  assign results.distance = o_dist;

  // arithmetic units
  phtst_mul #(.MW(MW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod(mul_prod)
  );

  phtst_div #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num($unsigned(dot)), .den(len2),
    .done(div_done), .quo(div_q)
  );

  phtst_sqrt #(.DW(DW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .value(best_min),
    .done(sqrt_done), .root(sqrt_root)
  );

  // checks
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    vertex_count != 2'd3) else $error("vertex count beyond two");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.hit |-> results.distance == '0)
    else $error("miss with nonzero distance");

  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> state == S_MUL_WAIT) else $error("multiplier busy outside wait");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(state) == S_EMIT) else $error("result without emit");

endmodule

// ===== tb/sv/polyline_hit_test_checker.sv =====
// checker for the polyline hit test: predicts each result and compares it
`timescale 1ns / 100ps

module polyline_hit_test_checker (
  input  logic                                clk,
  input  logic                                rst,
  phtst_vertex_if                             vtx,
  phtst_result_if                             res,
  input  logic                                wr_en,
  input  logic [phtst_pkg::CFG_IDX_WIDTH-1:0] wr_index,
  input  logic [phtst_pkg::TOL_WIDTH-1:0]     wr_data,
  output int                                  fail_count,
  output int                                  pending
);
  import phtst_pkg::*;

  typedef struct {
    logic                 hit;
    logic [TOL_WIDTH-1:0] distance;
  } hit_result_t;

  localparam longint unsigned NO_DIST = 64'hFFFF_FFFF_FFFF_FFFF;

  hit_result_t     hit_queue[$];

  // configuration copy
  logic                 cfg_closed;
  logic [TOL_WIDTH-1:0] cfg_tol;

  // polyline state copy
  longint          last_x, last_y, start_x, start_y, pt_x, pt_y;
  longint unsigned min_dsq;
  int              seen;

  assign pending = hit_queue.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // squared distance from the held query point to segment s..e
  function automatic longint unsigned seg_dsq(input longint sx, input longint sy,
                                              input longint ex, input longint ey);
    longint dx, dy, wx, wy, dot, t, px, py, rx, ry;
    longint unsigned len2, rem, quo;
    dx = ex - sx;
    dy = ey - sy;
    wx = pt_x - sx;
    wy = pt_y - sy;
    len2 = longint'(dx * dx) + longint'(dy * dy);
    px = sx;
    py = sy;
    if (len2 != 0) begin
      dot = wx * dx + wy * dy;
      if (dot <= 0) begin
        t = 0;
      end else if (longint'(dot) >= longint'(len2) || len2 <= dot) begin
        t = 65536;
      end else begin
        rem = dot;
        quo = 0;
        for (int i = 0; i < T_FRAC; i++) begin
          rem = rem << 1;
          quo = quo << 1;
          if (rem >= len2) begin
            rem = rem - len2;
            quo = quo | 1;
          end
        end
        t = quo;
      end
      // round half up then floor
      px = sx + ((t * dx + 32768) >>> 16);
      py = sy + ((t * dy + 32768) >>> 16);
    end
    rx = pt_x - px;
    ry = pt_y - py;
    return longint'(rx * rx) + longint'(ry * ry);
  endfunction

  // advance the polyline by one vertex, queue a result on the last one
  task automatic predict_vertex(input longint vx, input longint vy,
                                input longint qx, input longint qy, input logic fin);
    longint unsigned d, s;
    hit_result_t     r;
    if (seen == 0) begin
      pt_x = qx;
      pt_y = qy;
      start_x = vx;
      start_y = vy;
      min_dsq = NO_DIST;
      seen = 1;
    end else begin
      d = seg_dsq(last_x, last_y, vx, vy);
      if (d < min_dsq) min_dsq = d;
      seen = 2;
    end
    last_x = vx;
    last_y = vy;
    if (fin) begin
      r.hit = 1'b0;
      r.distance = '0;
      if (seen >= 2) begin
        if (cfg_closed) begin
          d = seg_dsq(vx, vy, start_x, start_y);
          if (d < min_dsq) min_dsq = d;
        end
        s = int_sqrt(min_dsq);
        if (s <= cfg_tol) begin
          r.hit = 1'b1;
          r.distance = s[TOL_WIDTH-1:0];
        end
      end
      hit_queue = {hit_queue, r};
      seen = 0;
      min_dsq = NO_DIST;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      cfg_closed <= 1'b0;
      cfg_tol <= '0;
      last_x = 0; last_y = 0; start_x = 0; start_y = 0; pt_x = 0; pt_y = 0;
      min_dsq = NO_DIST;
      seen = 0;
      hit_queue.delete();
    end else begin
      // result transfer against oldest expectation
      if (res.valid && res.ready) begin
        if (hit_queue.size() == 0) begin
          report("result with nothing expected");
        end else begin
          hit_result_t e;
          e = hit_queue.pop_front();
          if (res.hit !== e.hit)
            report($sformatf("hit got %0b want %0b", res.hit, e.hit));
          if (res.distance !== e.distance)
            report($sformatf("distance got %0d want %0d", res.distance, e.distance));
        end
      end
      // vertex transfer
      if (vtx.valid && vtx.ready)
        predict_vertex(longint'(vtx.vertex_x), longint'(vtx.vertex_y),
                       longint'(vtx.query_x), longint'(vtx.query_y), vtx.last_vertex);
      // register writes
      if (wr_en) begin
        if (wr_index == REG_CLOSED_MODE) cfg_closed <= wr_data[0];
        else if (wr_index == REG_TOLERANCE) cfg_tol <= wr_data;
      end
    end
  end
endmodule

// ===== tb/sv/polyline_hit_test_tb.sv =====
// testbench top for the polyline hit test: stimulus, stalls and verdict
`timescale 1ns / 100ps

module polyline_hit_test_tb;
  import phtst_pkg::*;

  localparam int WIDTH      = COORD_WIDTH_DEF;
  localparam int SETTLE     = 800;
  localparam int STUCK_MAX  = 20000;
  localparam int ITEM_GOAL  = 550;
  localparam logic [TOL_WIDTH-1:0] TOL_MAX = '1;

  typedef logic signed [WIDTH-1:0] coord_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] wr_index = REG_CLOSED_MODE;
  logic [TOL_WIDTH-1:0] wr_data = '0;
  int                   fail_count, pending;
  int                   items = 0;
  int                   stuck = 0;
  bit                   gaps_on = 1'b1;
  int                   stall_left = 0;

  phtst_vertex_if #(.COORD_WIDTH(WIDTH)) vtx();
  phtst_result_if                        res();

  polyline_hit_test #(.COORD_WIDTH(WIDTH)) DUT (
    .clk(clk), .rst(rst), .vertices(vtx), .results(res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  polyline_hit_test_checker chk (
    .clk(clk), .rst(rst), .vtx(vtx), .res(res),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side stall bursts
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 5);
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_MAX) begin
        $display("polyline_hit_test_tb: FAIL");
        $finish;
      end
    end
  end

  // one vertex transfer, called at a falling edge
  task automatic put_vertex(input coord_t x, input coord_t y,
                            input coord_t qx, input coord_t qy, input logic fin);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      vtx.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx.valid <= 1'b1;
    vtx.vertex_x <= x;
    vtx.vertex_y <= y;
    vtx.query_x <= qx;
    vtx.query_y <= qy;
    vtx.last_vertex <= fin;
    #1;
    while (!vtx.ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [TOL_WIDTH-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  // wait for every result plus the block's worst processing time
  task automatic drain();
    vtx.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic closed, input logic [TOL_WIDTH-1:0] tol);
    drain();
    write_reg(REG_CLOSED_MODE, TOL_WIDTH'(closed));
    write_reg(REG_TOLERANCE, tol);
  endtask

  function automatic coord_t near_coord(input coord_t base, input int spread);
    return base + coord_t'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // random polyline with a query point that often lies close to it
  task automatic random_polyline();
    int     n, spread, scale;
    coord_t cx, cy, x, y, qx, qy;
    n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
    scale = $urandom_range(0, 2);
    spread = (scale == 0) ? 16 : (scale == 1) ? 4096 : 1 << 20;
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    if (scale == 2 && $urandom_range(0, 1)) begin
      cx = 0;
      cy = 0;
      spread = (1 << 23) - 1;
    end
    x = near_coord(cx, spread);
    y = near_coord(cy, spread);
    if ($urandom_range(0, 1)) begin
      qx = near_coord(x, 300);
      qy = near_coord(y, 300);
    end else begin
      qx = (scale == 2) ? coord_t'($urandom) : near_coord(cx, spread);
      qy = (scale == 2) ? coord_t'($urandom) : near_coord(cy, spread);
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 15) != 0) begin
        x = near_coord(cx, spread);
        y = near_coord(cy, spread);
      end
      put_vertex(x, y, qx, qy, i == n - 1);
    end
  endtask

  initial begin
    logic [TOL_WIDTH-1:0] tol;
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.query_x = '0;
    vtx.query_y = '0;
    vtx.last_vertex = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: open mode, wide tolerance
    set_config(1'b0, TOL_MAX);
    put_vertex(0, 0, 5, 5, 1'b1);                             // lone vertex
    put_vertex(-24'sd8388608, -24'sd8388608, 24'sd8388607, -24'sd8388608, 1'b0);
    put_vertex(24'sd8388607, 24'sd8388607, 0, 0, 1'b1);       // full-range diagonal
    put_vertex(100, 100, 0, 0, 1'b0);
    put_vertex(100, 100, 0, 0, 1'b1);                         // zero-length segment
    put_vertex(0, 0, -500, 300, 1'b0);
    put_vertex(1000, 0, 0, 0, 1'b1);                          // before segment start
    put_vertex(0, 0, 2000, 300, 1'b0);
    put_vertex(1000, 0, 0, 0, 1'b1);                          // past segment end
    put_vertex(0, 0, 500, 301, 1'b0);
    put_vertex(1000, 7, 0, 0, 1'b1);                          // interior projection
    put_vertex(24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607, 1'b0);
    put_vertex(24'sd8388607, -24'sd8388608, 0, 0, 1'b1);      // far hit, zero length

    // directed: closed mode, exact and tight tolerances
    set_config(1'b1, 25'd200);
    put_vertex(0, 0, 10, 500, 1'b0);
    put_vertex(1000, 0, 0, 0, 1'b0);
    put_vertex(0, 1000, 0, 0, 1'b1);                          // near closing edge
    put_vertex(3, 3, 0, 0, 1'b1);                             // lone vertex, closed
    set_config(1'b1, 25'd0);
    put_vertex(-40, 20, -40, 20, 1'b0);
    put_vertex(60, 20, 0, 0, 1'b1);                           // query on vertex
    put_vertex(0, 0, 700, 900, 1'b0);
    put_vertex(1000, 0, 0, 0, 1'b0);
    put_vertex(0, 1000, 0, 0, 1'b1);                          // miss at zero tolerance

    // random phases across settings
    for (int ph = 0; items < ITEM_GOAL; ph++) begin
      case (ph % 6)
        0: tol = '0;
        1: tol = TOL_MAX;
        2: tol = TOL_WIDTH'($urandom_range(0, 400));
        3: tol = TOL_WIDTH'($urandom_range(0, 70000));
        4: tol = TOL_WIDTH'($urandom);
        default: tol = TOL_WIDTH'($urandom_range(100, 3000));
      endcase
      set_config(ph[0] ^ ph[2], tol);
      for (int k = 0; k < 20 && items < ITEM_GOAL; k++) begin
        gaps_on = (items < ITEM_GOAL - 80);
        random_polyline();
        // hold off until all results are in
        if (ph == 1 && k == 5) begin
          vtx.valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    // end of run
    gaps_on = 1'b0;
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("polyline_hit_test_tb: PASS");
    end else begin
      $display("polyline_hit_test_tb: FAIL");
    end
    $finish;
  end
endmodule
